[rtl/bis_pkg.sv]
// shared constants and types for the batch integer sorter
// no dependencies; compiled first
package bis_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic insert;    // place the incoming value into the sorted row
    logic set_ovf;   // note a dropped beat
    logic shift;     // smallest value taken, move the row down
    logic clear;     // batch done, empty the row
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;      // row holds MAX_ITEMS values
    logic last_one;  // one value left in the row
  } dp_status_t;

endpackage

[rtl/bis_if.sv]
// stream interfaces for input samples and sorted results
// depends on bis_pkg for field widths
interface bis_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bis_pkg::VALUE_W-1:0]  sample_value;
  logic                                is_final;

  modport source (output valid, output sample_value, output is_final, input ready);
  modport sink   (input valid, input sample_value, input is_final, output ready);
endinterface

interface bis_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [bis_pkg::VALUE_W-1:0]  sorted_value;
  logic                                final_out;
  logic                                overflowed;

  modport source (output valid, output sorted_value, output final_out,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input final_out,
                  input overflowed, output ready);
endinterface

[rtl/bis_ctrl.sv]
// controller state machine: load phase and emit phase
// depends on bis_pkg for state, command and status types
module bis_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_final,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bis_pkg::dp_status_t status,
  output bis_pkg::dp_cmd_t    cmd
);

  bis_pkg::state_t state;
  bis_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bis_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state)
      bis_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // a beat beyond capacity is dropped but still may end the batch
          cmd.insert  = !status.full;
          cmd.set_ovf = status.full;
          if (in_final) begin
            state_next = bis_pkg::ST_EMIT;
          end
        end
      end
      bis_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.last_one) begin
            cmd.clear  = 1'b1;
            state_next = bis_pkg::ST_LOAD;
          end else begin
            cmd.shift = 1'b1;
          end
        end
      end
      default: begin
        state_next = bis_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

[rtl/bis_datapath.sv]
// datapath: sorted row of value cells with insertion on load, shift on emit
// depends on bis_pkg for widths and command/status types
module bis_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  bis_pkg::dp_cmd_t                   cmd,
  output bis_pkg::dp_status_t                status,
  input  logic signed [bis_pkg::VALUE_W-1:0] sample_value,
  output logic signed [bis_pkg::VALUE_W-1:0] sorted_value,
  output logic                               final_out,
  output logic                               overflowed
);

  logic signed [bis_pkg::VALUE_W-1:0] cells [bis_pkg::MAX_ITEMS];
  logic signed [bis_pkg::VALUE_W-1:0] cells_next [bis_pkg::MAX_ITEMS];
  logic [bis_pkg::COUNT_W-1:0]        count;
  logic                               ovf;
  logic [bis_pkg::MAX_ITEMS-1:0]      above;

  // per cell: empty cells count as larger than anything
  always_comb begin
    for (int i = 0; i < bis_pkg::MAX_ITEMS; i++) begin
      above[i] = (bis_pkg::COUNT_W'(i) >= count) || (cells[i] > sample_value);
    end
  end

  // next row contents
  always_comb begin
    for (int i = 0; i < bis_pkg::MAX_ITEMS; i++) begin
      cells_next[i] = cells[i];
      if (cmd.insert) begin
        if (above[i]) begin
          if (i == 0) begin
            cells_next[i] = sample_value;
          end else if (!above[i-1]) begin
            cells_next[i] = sample_value;
          end else begin
            cells_next[i] = cells[i-1];
          end
        end
      end else if (cmd.shift) begin
        if (i < bis_pkg::MAX_ITEMS - 1) begin
          cells_next[i] = cells[i+1];
        end
      end
    end
  end

  // value cells, no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < bis_pkg::MAX_ITEMS; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  // fill count and overflow flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= count + bis_pkg::COUNT_W'(1);
      end else if (cmd.shift) begin
        count <= count - bis_pkg::COUNT_W'(1);
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
    end
  end

  assign status.full     = (count == bis_pkg::COUNT_W'(bis_pkg::MAX_ITEMS));
  assign status.last_one = (count == bis_pkg::COUNT_W'(1));

  // result beat straight from the head cell
  assign sorted_value = cells[0];
  assign final_out    = status.last_one;
  assign overflowed   = ovf;

endmodule

[rtl/batch_integer_sorter_core.sv]
// batch integer sorter: one input beat per cycle during load; ready is low while
// a batch is emitted. The first result is valid the cycle after the final beat,
// then one result per cycle while the receiver is ready; each load step inserts
// the beat straight into its place in the sorted cell row.
// Reset (rst, synchronous) empties the batch and clears the overflow flag.
module batch_integer_sorter_core (
  input  logic        clk,
  input  logic        rst,
  bis_in_if.sink      samples,
  bis_out_if.source   results
);

  bis_pkg::dp_cmd_t    cmd;
  bis_pkg::dp_status_t status;

  // control
  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_final  (samples.is_final),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // data
  bis_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_value (samples.sample_value),
    .sorted_value (results.sorted_value),
    .final_out    (results.final_out),
    .overflowed   (results.overflowed)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// self-checking bench for batch_integer_sorter_core: feeds batches of signed samples and
// checks each sorted result beat against an in-bench ordering model
// depends on bis_pkg and the bis_in_if / bis_out_if stream interfaces
module testbench;

  typedef logic signed [bis_pkg::VALUE_W-1:0] sample_t;

  typedef struct packed {
    sample_t sorted_value;
    logic    final_out;
    logic    overflowed;
  } sorted_beat_t;

  localparam sample_t MOST_NEGATIVE = {1'b1, {(bis_pkg::VALUE_W-1){1'b0}}};
  localparam sample_t MOST_POSITIVE = {1'b0, {(bis_pkg::VALUE_W-1){1'b1}}};
  localparam int      RUN_LIMIT_NS  = 2_000_000;
  localparam int      LONG_HOLD     = 200;
  localparam int      SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bis_in_if  sample_ch ();
  bis_out_if result_ch ();

  batch_integer_sorter_core DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch)
  );

  // ordering model state: values of the open batch, kept ascending
  sample_t      held_values[$];
  logic         batch_dropped = 1'b0;
  sorted_beat_t due_results[$];
  int           fault_count   = 0;
  int           items_sent    = 0;
  bit           idle_on       = 1'b1;
  int           hold_request  = 0;
  int           sink_gap      = 0;

  always #4 clk = ~clk;

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // result side: random ready bursts, or a long hold when one is asked for
  initial result_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (hold_request != 0) begin
      sink_gap = hold_request;
      hold_request = 0;
    end else if (sink_gap == 0 && idle_on && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(1, 6);
    end
    if (sink_gap != 0) begin
      result_ch.ready <= 1'b0;
      sink_gap--;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // store an accepted sample; a final beat releases the whole batch in order
  function automatic void absorb_sample(sample_t value, logic last);
    int           slot;
    sorted_beat_t beat;
    if (held_values.size() < bis_pkg::MAX_ITEMS) begin
      held_values.push_back(value);
      slot = held_values.size() - 1;
      while (slot > 0 && held_values[slot-1] > value) begin
        held_values[slot] = held_values[slot-1];
        slot--;
      end
      held_values[slot] = value;
    end else begin
      batch_dropped = 1'b1;
    end
    if (last) begin
      for (int k = 0; k < held_values.size(); k++) begin
        beat.sorted_value = held_values[k];
        beat.final_out    = (k == held_values.size() - 1);
        beat.overflowed   = batch_dropped;
        due_results.push_back(beat);
      end
      held_values.delete();
      batch_dropped = 1'b0;
    end
  endfunction

  // compare one result beat with the oldest expectation
  function automatic void check_result();
    sorted_beat_t want;
    if (due_results.size() == 0) begin
      $display("%0t ns: result beat with none expected, got value %0d final %b overflow %b",
               $time, result_ch.sorted_value, result_ch.final_out, result_ch.overflowed);
      fault_count++;
    end else begin
      want = due_results.pop_front();
      if (result_ch.sorted_value !== want.sorted_value) begin
        $display("%0t ns: sorted_value expected %0d got %0d",
                 $time, want.sorted_value, result_ch.sorted_value);
        fault_count++;
      end
      if (result_ch.final_out !== want.final_out) begin
        $display("%0t ns: final_out expected %b got %b",
                 $time, want.final_out, result_ch.final_out);
        fault_count++;
      end
      if (result_ch.overflowed !== want.overflowed) begin
        $display("%0t ns: overflowed expected %b got %b",
                 $time, want.overflowed, result_ch.overflowed);
        fault_count++;
      end
    end
  endfunction

  // both channels sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) check_result();
      if (sample_ch.valid && sample_ch.ready)
        absorb_sample(sample_ch.sample_value, sample_ch.is_final);
    end
  end

  // offer one beat from a falling edge; returns on the falling edge after acceptance
  task automatic send_sample(input sample_t value, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      sample_ch.valid        <= 1'b0;
      sample_ch.sample_value <= $urandom;
      sample_ch.is_final     <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.sample_value <= value;
    sample_ch.is_final     <= last;
    do @(posedge clk); while (!sample_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // mix of extremes, near-zero ties and full-range values
  function automatic sample_t pick_value();
    case ($urandom_range(0, 9))
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2, 3:    return sample_t'(int'($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_batch(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_value(), i == len - 1);
  endtask

  // drop valid and wait for every expected result
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic test_single_element();
    send_sample(-1, 1'b1);
    send_sample(MOST_POSITIVE, 1'b1);
  endtask

  // extremes, ties and alternating bit patterns in one batch, then a short second batch
  task automatic test_extremes();
    send_sample(MOST_POSITIVE, 1'b0);
    send_sample(MOST_NEGATIVE, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
    send_sample(MOST_POSITIVE, 1'b0);
    send_sample(MOST_NEGATIVE, 1'b0);
    send_sample(sample_t'(32'h5555_5555), 1'b0);
    send_sample(sample_t'(32'hAAAA_AAAA), 1'b0);
    send_sample(1, 1'b1);
    send_sample(-5, 1'b0);
    send_sample(7, 1'b1);
  endtask

  // exactly full, final beat dropped, several dropped, then a clean batch
  task automatic test_capacity();
    send_batch(bis_pkg::MAX_ITEMS);
    send_batch(bis_pkg::MAX_ITEMS + 1);
    send_batch(bis_pkg::MAX_ITEMS + 8);
    send_batch(3);
  endtask

  // receiver holds off while batches keep coming, so the input stalls
  task automatic test_output_hold();
    hold_request = LONG_HOLD;
    send_batch(12);
    send_batch(5);
    send_batch(bis_pkg::MAX_ITEMS);
  endtask

  // sender waits for each batch to drain before the next
  task automatic test_drain_pause();
    for (int b = 0; b < 3; b++) begin
      send_batch($urandom_range(1, 8));
      wait_drained();
    end
  endtask

  task automatic test_random_batches(input int count);
    int stop_at;
    int len;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0:       len = $urandom_range(bis_pkg::MAX_ITEMS + 1, bis_pkg::MAX_ITEMS + 8);
        1, 2:    len = $urandom_range(9, bis_pkg::MAX_ITEMS);
        default: len = $urandom_range(1, 8);
      endcase
      send_batch(len);
    end
    idle_on = 1'b1;
  endtask

  // last part: no idling on either side
  task automatic test_streaming();
    idle_on = 1'b0;
    for (int b = 0; b < 8; b++) send_batch($urandom_range(1, 8));
  endtask

  initial begin
    sample_ch.valid        = 1'b0;
    sample_ch.sample_value = '0;
    sample_ch.is_final     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_single_element();
    test_extremes();
    test_capacity();
    test_output_hold();
    test_drain_pause();
    test_random_batches(150);
    test_streaming();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bis_pkg.sv
rtl/bis_if.sv
rtl/bis_ctrl.sv
rtl/bis_datapath.sv
rtl/batch_integer_sorter_core.sv
test/testbench.sv
